>>> rtl/rles_pkg.sv
// Shared types and constants for the RGB LED effect sequencer.
// Used by rles_chan and rgb_led_effect_sequencer_core; no dependencies.
package rles_pkg;

    // Stream payload widths; tdata is padded with zeros to whole bytes.
    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 56;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] ADDR_MAX_BRIGHT = 3'd0;

    // Output packing covers at most two LEDs of three colors and six lit bits.
    localparam int PACK_LEDS   = 2;
    localparam int PACK_COLORS = 3;
    localparam int LIT_BITS    = 6;

    localparam logic [7:0] ALERT_STEP = 8'd2;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_STEADY = 3'd1,
        OP_PULSE  = 3'd2,
        OP_CYCLE  = 3'd3,
        OP_STOP   = 3'd4,
        OP_ALERT  = 3'd5
    } op_t;

    typedef enum logic [5:0] {
        MODE_OFF     = 6'b000001,
        MODE_STEADY  = 6'b000010,
        MODE_PULSE   = 6'b000100,
        MODE_ALERT   = 6'b001000,
        MODE_CYC_OFF = 6'b010000,
        MODE_CYC_ON  = 6'b100000
    } mode_t;

    // Decoded operation, shared by all channels.
    typedef struct packed {
        logic tick;
        logic steady;
        logic pulse;
        logic cycle;
        logic stop;
        logic alert;
    } cmd_t;

endpackage

>>> rtl/rgb_led_effect_sequencer_core.sv
// Top level of the RGB LED effect sequencer: input register, channel array,
// result register and configuration port. Depends on rles_pkg and rles_chan.
//
// Usage:
// The s_ channel carries one item per transfer: s_tuser is the operation
// (tick, steady, pulse, cycle, stop, alert) and s_tdata the channel address
// and command arguments. A tick advances the millisecond counter and updates
// every channel; a command changes the addressed channel only. Every item
// yields exactly one transfer on the m_ channel with both packed colors and
// the lit mask after the item has been applied.
// The input register takes the item at the transfer, and the channel update
// loads the result register from it once that register is free.
// Throughput is one item per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and the input register
// absorbs one more item before s_tready drops.
// Reset (aresetn low, synchronous) clears the counter, all channels to off
// at level zero, and sets max_brightness to 255. The APB port holds
// max_brightness at address 0; write it only while no item is in flight.
module rgb_led_effect_sequencer_core import rles_pkg::*; #(
    parameter int LED_COUNT      = 2,
    parameter int COLORS_PER_LED = 3
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata from bit 0: led_index[0], color_index[2:1], level[10:3],
    // period_ms[42:11], on_time_ms[74:43], zero padding.
    input  logic [S_TDATA_W-1:0] s_tdata,
    // tuser: operation[2:0].
    input  logic [S_TUSER_W-1:0] s_tuser,
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tdata from bit 0: first_color[23:0], second_color[47:24],
    // lit_mask[53:48], zero padding.
    output logic [M_TDATA_W-1:0] m_tdata,
    // Configuration port.
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    localparam int CHANNELS = LED_COUNT * COLORS_PER_LED;

    logic        in_valid_reg;
    logic [2:0]  in_op_reg;
    logic        in_led_reg;
    logic [1:0]  in_color_reg;
    logic [7:0]  in_level_reg;
    logic [31:0] in_period_reg;
    logic [31:0] in_on_time_reg;

    logic        out_valid_reg;
    logic [23:0] first_color_reg;
    logic [23:0] second_color_reg;
    logic [5:0]  lit_mask_reg;

    logic [31:0] now_ms_reg, now_ms_next;
    logic [7:0]  max_bright_reg;

    logic        out_free;
    logic        consume;
    cmd_t        cmd;
    logic [7:0]  chan_level_next [CHANNELS];
    logic [7:0]  color_byte [PACK_LEDS][PACK_COLORS];
    logic [5:0]  lit_mask;

    // Handshake: the result register empties or is taken, then the input
    // register can move forward and take a new transfer in the same cycle.
    assign out_free = !out_valid_reg || m_tready;
    assign consume  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_comb begin
        cmd = '0;
        unique case (in_op_reg)
            OP_TICK:   cmd.tick   = 1'b1;
            OP_STEADY: cmd.steady = 1'b1;
            OP_PULSE:  cmd.pulse  = 1'b1;
            OP_CYCLE:  cmd.cycle  = 1'b1;
            OP_STOP:   cmd.stop   = 1'b1;
            OP_ALERT:  cmd.alert  = 1'b1;
            default:   cmd = '0;
        endcase
    end

    // A tick advances the counter before the channels compare against it.
    assign now_ms_next = (consume && cmd.tick) ? now_ms_reg + 32'd1 : now_ms_reg;

    for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
        localparam int LED_I   = i / COLORS_PER_LED;
        localparam int COLOR_I = i % COLORS_PER_LED;
        logic sel;

        assign sel = (32'(in_led_reg) == LED_I) && (32'(in_color_reg) == COLOR_I);

        rles_chan u_chan (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .en             (consume),
            .sel            (sel),
            .cmd            (cmd),
            .cmd_level      (in_level_reg),
            .cmd_period     (in_period_reg),
            .cmd_on_time    (in_on_time_reg),
            .now_ms         (now_ms_next),
            .max_brightness (max_bright_reg),
            .level_next     (chan_level_next[i])
        );
    end

    // Colors or LEDs that do not exist read as zero.
    for (genvar l = 0; l < PACK_LEDS; l++) begin : g_pack_led
        for (genvar c = 0; c < PACK_COLORS; c++) begin : g_pack_color
            if (l < LED_COUNT && c < COLORS_PER_LED) begin : g_used
                assign color_byte[l][c] = chan_level_next[l * COLORS_PER_LED + c];
            end else begin : g_unused
                assign color_byte[l][c] = 8'd0;
            end
        end
    end

    for (genvar i = 0; i < LIT_BITS; i++) begin : g_lit
        if (i < CHANNELS) begin : g_used
            assign lit_mask[i] = |chan_level_next[i];
        end else begin : g_unused
            assign lit_mask[i] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            now_ms_reg    <= 32'd0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            now_ms_reg <= now_ms_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg      <= s_tuser;
            in_led_reg     <= s_tdata[0];
            in_color_reg   <= s_tdata[2:1];
            in_level_reg   <= s_tdata[10:3];
            in_period_reg  <= s_tdata[42:11];
            in_on_time_reg <= s_tdata[74:43];
        end
        if (consume) begin
            first_color_reg  <= {color_byte[0][0], color_byte[0][1], color_byte[0][2]};
            second_color_reg <= {color_byte[1][0], color_byte[1][1], color_byte[1][2]};
            lit_mask_reg     <= lit_mask;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, lit_mask_reg, second_color_reg, first_color_reg};

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bright_reg <= 8'hff;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_MAX_BRIGHT) begin
            max_bright_reg <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MAX_BRIGHT) ? {24'd0, max_bright_reg} : '0;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !in_valid_reg))
        else $error("pipeline holds an item after reset");
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while both stages are full and stalled");
    a_tick_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && cmd.tick) |=> (now_ms_reg == $past(now_ms_reg) + 32'd1))
        else $error("tick did not advance the millisecond counter");
    a_lit_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[48] == (m_tdata[23:16] != 8'd0)))
        else $error("lit mask disagrees with the first channel level");
`endif

endmodule

>>> rtl/rles_chan.sv
// One LED color channel: mode, level, start stamp and phase lengths.
// Depends on rles_pkg for the mode encoding and the decoded command struct.
module rles_chan import rles_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        sel,
    input  cmd_t        cmd,
    input  logic [7:0]  cmd_level,
    input  logic [31:0] cmd_period,
    input  logic [31:0] cmd_on_time,
    input  logic [31:0] now_ms,
    input  logic [7:0]  max_brightness,
    output logic [7:0]  level_next
);

    mode_t       mode_reg, mode_next;
    logic [7:0]  level_reg;
    logic [31:0] stamp_reg, stamp_next;
    logic [31:0] pulse_len_reg, pulse_len_next;
    logic [31:0] off_len_reg, off_len_next;
    logic [31:0] on_len_reg, on_len_next;
    logic [31:0] elapsed;
    logic [7:0]  level_dec;

    // Elapsed time wraps modulo 2^32 like the counter itself.
    assign elapsed   = now_ms - stamp_reg;
    assign level_dec = level_reg - 8'd1;

    always_comb begin
        mode_next      = mode_reg;
        level_next     = level_reg;
        stamp_next     = stamp_reg;
        pulse_len_next = pulse_len_reg;
        off_len_next   = off_len_reg;
        on_len_next    = on_len_reg;
        if (en && cmd.tick) begin
            unique case (mode_reg)
                MODE_OFF: begin
                    level_next = 8'd0;
                end
                MODE_STEADY: begin
                end
                MODE_PULSE: begin
                    if (elapsed >= pulse_len_reg) begin
                        level_next = 8'd0;
                        mode_next  = MODE_OFF;
                    end
                end
                MODE_ALERT: begin
                    if (elapsed >= {24'd0, ALERT_STEP}) begin
                        level_next = (level_dec == 8'd0) ? max_brightness : level_dec;
                        stamp_next = now_ms;
                    end
                end
                MODE_CYC_OFF: begin
                    if (elapsed >= off_len_reg) begin
                        level_next = max_brightness;
                        mode_next  = MODE_CYC_ON;
                        stamp_next = now_ms;
                    end
                end
                MODE_CYC_ON: begin
                    if (elapsed >= on_len_reg) begin
                        level_next = 8'd0;
                        mode_next  = MODE_CYC_OFF;
                        stamp_next = now_ms;
                    end
                end
                default: begin
                end
            endcase
        end else if (en && sel) begin
            if (cmd.steady) begin
                level_next = cmd_level;
                mode_next  = MODE_STEADY;
            end
            if (cmd.pulse) begin
                stamp_next     = now_ms;
                pulse_len_next = cmd_period;
                level_next     = max_brightness;
                mode_next      = MODE_PULSE;
            end
            // A running cycle is not restarted.
            if (cmd.cycle && mode_reg != MODE_CYC_ON && mode_reg != MODE_CYC_OFF) begin
                off_len_next = cmd_period;
                on_len_next  = cmd_on_time;
                stamp_next   = now_ms;
                level_next   = max_brightness;
                mode_next    = MODE_CYC_ON;
            end
            if (cmd.stop) begin
                level_next = 8'd0;
                mode_next  = MODE_OFF;
            end
            // Entering alert keeps the old stamp.
            if (cmd.alert && mode_reg != MODE_ALERT) begin
                level_next = max_brightness;
                mode_next  = MODE_ALERT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_OFF;
            level_reg     <= 8'd0;
            stamp_reg     <= 32'd0;
            pulse_len_reg <= 32'd0;
            off_len_reg   <= 32'd0;
            on_len_reg    <= 32'd0;
        end else begin
            mode_reg      <= mode_next;
            level_reg     <= level_next;
            stamp_reg     <= stamp_next;
            pulse_len_reg <= pulse_len_next;
            off_len_reg   <= off_len_next;
            on_len_reg    <= on_len_next;
        end
    end

`ifndef SYNTHESIS
    a_off_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_OFF) |-> (level_reg == 8'd0))
        else $error("channel is off but its level is nonzero");
    a_cyc_off_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_CYC_OFF) |-> (level_reg == 8'd0))
        else $error("channel is in the dark cycle phase but lit");
    a_unaddressed_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && !cmd.tick && !sel) |=> ($stable(level_reg) && $stable(mode_reg)))
        else $error("command changed a channel it does not address");
`endif

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for rgb_led_effect_sequencer_core: streams ticks and
// channel commands, predicts every result frame and compares it field by field.
// Depends on rles_pkg and the sequencer RTL only.
module tb_top import rles_pkg::*; ();

    localparam int LEDS           = 2;
    localparam int COLORS         = 3;
    localparam int CHANNELS       = LEDS * COLORS;
    localparam int DIR_ROWS       = 25;
    localparam int PHASES         = 7;
    localparam int PHASE_ITEMS    = 246;
    localparam int HOLD_PHASE     = 4;
    localparam int FLOW_PHASE     = 2;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_LIMIT      = 2000;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [2:0] OP_UNDEF_A = 3'd6;
    localparam logic [2:0] OP_UNDEF_B = 3'd7;

    // max_brightness per random phase; the random phase draws its own value.
    localparam logic [7:0] BRIGHT_PLAN [PHASES] = '{8'd0, 8'd1, 8'd3, 8'd255, 8'd0,
                                                   8'd128, 8'd254};

    typedef struct packed {
        logic [2:0]  op;
        logic        led;
        logic [1:0]  color;
        logic [7:0]  lvl;
        logic [31:0] period;
        logic [31:0] ontime;
    } item_t;

    typedef struct packed {
        logic [23:0] first;
        logic [23:0] second;
        logic [5:0]  lit;
    } led_frame_t;

    typedef struct packed {
        item_t      item;
        logic       set_max;
        logic [7:0] max_val;
        logic       typed;
        led_frame_t want;
    } dir_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [APB_AW-1:0]    paddr    = '0;
    logic [APB_DW-1:0]    pwdata   = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // Mirror of the block's state.
    logic [31:0] ms_count = '0;
    mode_t       ch_mode  [CHANNELS] = '{default: MODE_OFF};
    logic [7:0]  ch_level [CHANNELS] = '{default: '0};
    logic [31:0] ch_stamp [CHANNELS] = '{default: '0};
    logic [31:0] ch_pulse [CHANNELS] = '{default: '0};
    logic [31:0] ch_off   [CHANNELS] = '{default: '0};
    logic [31:0] ch_on    [CHANNELS] = '{default: '0};
    logic [7:0]  bright_max = 8'd255;

    led_frame_t frame_q [$];
    led_frame_t mon_want;
    int         err_count    = 0;
    int         items_sent   = 0;
    int         ticks_sent   = 0;
    int         frames_seen  = 0;
    int         quiet_cycles = 0;
    bit         steady_flow  = 1'b0;
    bit         holdoff_req  = 1'b0;

    // Expected frames are typed in only where they follow at a glance.
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{'{OP_TICK,    1'b0, 2'd0, 8'h00, 32'h0, 32'h0},
          1'b0, 8'h00, 1'b1, '{24'h000000, 24'h000000, 6'h00}},
        '{'{OP_STEADY,  1'b0, 2'd0, 8'hff, 32'h0, 32'h0},
          1'b0, 8'h00, 1'b1, '{24'hff0000, 24'h000000, 6'h01}},
        '{'{OP_STEADY,  1'b1, 2'd2, 8'h01, 32'h0, 32'h0},
          1'b0, 8'h00, 1'b1, '{24'hff0000, 24'h000001, 6'h21}},
        '{'{OP_STEADY,  1'b0, 2'd3, 8'haa, 32'h0, 32'h0},
          1'b0, 8'h00, 1'b1, '{24'hff0000, 24'h000001, 6'h21}},
        '{'{OP_UNDEF_A, 1'b0, 2'd0, 8'h55, 32'h5, 32'h0},
          1'b0, 8'h00, 1'b1, '{24'hff0000, 24'h000001, 6'h21}},
        '{'{OP_UNDEF_B, 1'b1, 2'd3, 8'hff, 32'hffffffff, 32'hffffffff},
          1'b0, 8'h00, 1'b1, '{24'hff0000, 24'h000001, 6'h21}},
        '{'{OP_STOP,    1'b0, 2'd0, 8'h00, 32'h0, 32'h0},
          1'b0, 8'h00, 1'b1, '{24'h000000, 24'h000001, 6'h20}},
        '{'{OP_PULSE,   1'b0, 2'd1, 8'h00, 32'h0, 32'h0},
          1'b0, 8'h00, 1'b1, '{24'h00ff00, 24'h000001, 6'h22}},
        '{'{OP_TICK,    1'b0, 2'd0, 8'h00, 32'h0, 32'h0},
          1'b0, 8'h00, 1'b1, '{24'h000000, 24'h000001, 6'h20}},
        '{'{OP_PULSE,   1'b1, 2'd0, 8'h00, 32'hffffffff, 32'h0},
          1'b0, 8'h00, 1'b1, '{24'h000000, 24'hff0001, 6'h28}},
        '{'{OP_CYCLE,   1'b0, 2'd2, 8'h00, 32'h1, 32'h0},
          1'b0, 8'h00, 1'b0, '0},
        '{'{OP_CYCLE,   1'b0, 2'd2, 8'h00, 32'h7, 32'hffffffff},
          1'b0, 8'h00, 1'b0, '0},
        '{'{OP_TICK,    1'b0, 2'd0, 8'h00, 32'h0, 32'h0},
          1'b0, 8'h00, 1'b0, '0},
        '{'{OP_TICK,    1'b1, 2'd3, 8'hff, 32'hffffffff, 32'hffffffff},
          1'b0, 8'h00, 1'b0, '0},
        '{'{OP_ALERT,   1'b1, 2'd1, 8'h00, 32'h0, 32'h0},
          1'b0, 8'h00, 1'b0, '0},
        '{'{OP_ALERT,   1'b1, 2'd1, 8'h00, 32'h0, 32'h0},
          1'b0, 8'h00, 1'b0, '0},
        '{'{OP_TICK,    1'b0, 2'd0, 8'h00, 32'h0, 32'h0},
          1'b0, 8'h00, 1'b0, '0},
        '{'{OP_TICK,    1'b0, 2'd0, 8'h00, 32'h0, 32'h0},
          1'b0, 8'h00, 1'b0, '0},
        '{'{OP_ALERT,   1'b0, 2'd0, 8'h00, 32'h0, 32'h0},
          1'b1, 8'h00, 1'b0, '0},
        '{'{OP_TICK,    1'b0, 2'd0, 8'h00, 32'h0, 32'h0},
          1'b0, 8'h00, 1'b0, '0},
        '{'{OP_TICK,    1'b0, 2'd0, 8'h00, 32'h0, 32'h0},
          1'b0, 8'h00, 1'b0, '0},
        '{'{OP_TICK,    1'b0, 2'd0, 8'h00, 32'h0, 32'h0},
          1'b0, 8'h00, 1'b0, '0},
        '{'{OP_PULSE,   1'b0, 2'd1, 8'h00, 32'h3, 32'h0},
          1'b0, 8'h00, 1'b0, '0},
        '{'{OP_STEADY,  1'b1, 2'd0, 8'h00, 32'h0, 32'h0},
          1'b0, 8'h00, 1'b0, '0},
        '{'{OP_STOP,    1'b1, 2'd3, 8'h00, 32'h0, 32'h0},
          1'b0, 8'h00, 1'b0, '0}
    };

    rgb_led_effect_sequencer_core #(
        .LED_COUNT      (LEDS),
        .COLORS_PER_LED (COLORS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Applies one item to the mirrored channels and returns the frame it yields.
    function automatic led_frame_t apply_item(input item_t it);
        logic [31:0] elapsed;
        int          ch;
        led_frame_t  frame;
        ch = int'(it.led) * COLORS + int'(it.color);
        if (it.op == OP_TICK) begin
            ms_count = ms_count + 32'd1;
            for (int i = 0; i < CHANNELS; i++) begin
                elapsed = ms_count - ch_stamp[i];
                case (ch_mode[i])
                    MODE_OFF: ch_level[i] = '0;
                    MODE_PULSE: if (elapsed >= ch_pulse[i]) begin
                        ch_level[i] = '0;
                        ch_mode[i]  = MODE_OFF;
                    end
                    MODE_ALERT: if (elapsed >= 32'(ALERT_STEP)) begin
                        ch_level[i] = ch_level[i] - 8'd1;
                        ch_stamp[i] = ms_count;
                        if (ch_level[i] == 8'd0)
                            ch_level[i] = bright_max;
                    end
                    MODE_CYC_OFF: if (elapsed >= ch_off[i]) begin
                        ch_level[i] = bright_max;
                        ch_mode[i]  = MODE_CYC_ON;
                        ch_stamp[i] = ms_count;
                    end
                    MODE_CYC_ON: if (elapsed >= ch_on[i]) begin
                        ch_level[i] = '0;
                        ch_mode[i]  = MODE_CYC_OFF;
                        ch_stamp[i] = ms_count;
                    end
                    default: ;
                endcase
            end
        end else if (int'(it.color) < COLORS) begin
            case (it.op)
                OP_STEADY: begin
                    ch_level[ch] = it.lvl;
                    ch_mode[ch]  = MODE_STEADY;
                end
                OP_PULSE: begin
                    ch_stamp[ch] = ms_count;
                    ch_pulse[ch] = it.period;
                    ch_mode[ch]  = MODE_PULSE;
                    ch_level[ch] = bright_max;
                end
                OP_CYCLE: if (ch_mode[ch] != MODE_CYC_ON && ch_mode[ch] != MODE_CYC_OFF) begin
                    ch_off[ch]   = it.period;
                    ch_on[ch]    = it.ontime;
                    ch_stamp[ch] = ms_count;
                    ch_mode[ch]  = MODE_CYC_ON;
                    ch_level[ch] = bright_max;
                end
                OP_STOP: begin
                    ch_mode[ch]  = MODE_OFF;
                    ch_level[ch] = '0;
                end
                OP_ALERT: if (ch_mode[ch] != MODE_ALERT) begin
                    ch_mode[ch]  = MODE_ALERT;
                    ch_level[ch] = bright_max;
                end
                default: ;
            endcase
        end
        frame.first  = {ch_level[0], ch_level[1], ch_level[2]};
        frame.second = {ch_level[3], ch_level[4], ch_level[5]};
        for (int i = 0; i < CHANNELS; i++)
            frame.lit[i] = (ch_level[i] != 8'd0);
        return frame;
    endfunction

    // About half ticks; short lengths so pulses and cycles expire during the run.
    function automatic item_t rand_item();
        item_t it;
        int    pick;
        pick      = $urandom_range(99);
        it.led    = 1'($urandom_range(1));
        it.color  = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
        it.lvl    = 8'($urandom_range(255));
        it.period = ($urandom_range(7) == 0) ? $urandom : $urandom_range(12);
        it.ontime = ($urandom_range(7) == 0) ? $urandom : $urandom_range(12);
        if (pick < 45)
            it.op = OP_TICK;
        else if (pick < 97)
            it.op = 3'($urandom_range(OP_ALERT, OP_STEADY));
        else
            it.op = ($urandom_range(1) == 0) ? OP_UNDEF_A : OP_UNDEF_B;
        return it;
    endfunction

    task automatic send_item(input item_t it, input bit typed, input led_frame_t want);
        led_frame_t predicted;
        while (!steady_flow && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= S_TDATA_W'({it.ontime, it.period, it.lvl, it.color, it.led});
        do @(posedge aclk); while (!s_tready);
        predicted = apply_item(it);
        frame_q.push_back(typed ? want : predicted);
        items_sent++;
        if (it.op == OP_TICK)
            ticks_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (frame_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes max_brightness, then reads it back over the same port.
    task automatic write_max(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_BRIGHT;
        pwdata  <= APB_DW'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        bright_max = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== APB_DW'(value)) begin
            $error("max_brightness readback mismatch: expected %h, actual %h",
                   APB_DW'(value), prdata);
            err_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int         wait_cycles;
        logic [7:0] phase_max;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].set_max) begin
                drain_results();
                write_max(dir_rows[r].max_val);
            end
            send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            phase_max = (ph == HOLD_PHASE) ? 8'($urandom_range(255)) : BRIGHT_PLAN[ph];
            write_max(phase_max);
            steady_flow = (ph == FLOW_PHASE);
            if (ph == HOLD_PHASE)
                holdoff_req = 1'b1;
            repeat (PHASE_ITEMS) send_item(rand_item(), 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        wait_cycles = 0;
        while (frame_q.size() != 0 && wait_cycles < END_LIMIT) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (frame_q.size() != 0) begin
            $error("%0d result frames never arrived", frame_q.size());
            err_count++;
        end
        $display("Checked %0d frames from %0d items (%0d ticks) across %0d brightness settings,",
                 frames_seen, items_sent, ticks_sent, PHASES + 2);
        $display("with random stalls on both sides, one long output hold-off and a stall-free run.");
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Result side: random back-pressure, a stall-free phase and one long hold-off.
    initial begin
        forever begin
            @(posedge aclk);
            if (holdoff_req) begin
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
                holdoff_req = 1'b0;
            end else if (steady_flow) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 36);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (frame_q.size() == 0) begin
                $error("result transfer with no frame expected: tdata %h", m_tdata);
                err_count++;
            end else begin
                mon_want = frame_q.pop_front();
                frames_seen++;
                if (m_tdata[23:0] !== mon_want.first) begin
                    $error("first_color mismatch: expected %h, actual %h",
                           mon_want.first, m_tdata[23:0]);
                    err_count++;
                end
                if (m_tdata[47:24] !== mon_want.second) begin
                    $error("second_color mismatch: expected %h, actual %h",
                           mon_want.second, m_tdata[47:24]);
                    err_count++;
                end
                if (m_tdata[53:48] !== mon_want.lit) begin
                    $error("lit_mask mismatch: expected %h, actual %h",
                           mon_want.lit, m_tdata[53:48]);
                    err_count++;
                end
            end
        end
    end

    // Ends the run when no transfer happens on either stream for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

>>> rgb_led_effect_sequencer_core.f
rtl/rles_pkg.sv
rtl/rles_chan.sv
rtl/rgb_led_effect_sequencer_core.sv
tb/sv/tb_top.sv
